>>> hw/rtl/rotate_point_about_center_unit_defines.svh
// ============================================================================
// Assertion macros for the point rotation unit
// Shared checks written as concurrent assertions on a clock and a reset.
// ============================================================================
`ifndef ROTATE_POINT_ABOUT_CENTER_UNIT_DEFINES_SVH
`define ROTATE_POINT_ABOUT_CENTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RPAC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rpac_pkg.sv
// ============================================================================
// rpac_pkg
// Types, angle table and gain constants for the point rotation unit.
// ============================================================================
package rpac_pkg;

   localparam int GUARD_BITS  = 8;
   localparam int GAIN_SHIFT  = 30;
   localparam int ANGLE_WIDTH = 16;
   localparam int ZWIDTH      = 32;
   localparam int MIN_STAGES  = 8;
   localparam int MAX_STAGES  = 30;
   localparam int GAIN_ENTRIES = 8;

   // Quadrant picked from the top angle bits (angle rounded to a quarter turn)
   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   // Angle accumulator, units of 2^-32 turn
   typedef logic signed [ZWIDTH-1:0] angle_acc_type;

   typedef logic [GAIN_SHIFT-1:0] gain_type;

   // atan(2^-i) in units of 2^-32 turn, rounded to nearest
   localparam angle_acc_type ATAN_TURN32 [MAX_STAGES] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1
   };

   // 1/K in Q30 for 8..14 stages; 15 and up use the last entry
   localparam gain_type GAIN_Q30 [GAIN_ENTRIES] = '{
      30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978,
      30'd652032900, 30'd652032881, 30'd652032876, 30'd652032874
   };

endpackage

>>> hw/rtl/rpac_channel_if.sv
// ============================================================================
// rpac channel interfaces
// Valid/ready channels for request and response beats of the rotation unit.
// ============================================================================
interface rpac_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic [rpac_pkg::ANGLE_WIDTH-1:0] turn_angle;

   modport source (output valid, output point_x, output point_y, output center_x,
                   output center_y, output turn_angle, input ready);
   modport sink   (input valid, input point_x, input point_y, input center_x,
                   input center_y, input turn_angle, output ready);
endinterface

interface rpac_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rotated_x;
   logic signed [COORD_WIDTH-1:0] rotated_y;
   logic                          saturated;

   modport source (output valid, output rotated_x, output rotated_y,
                   output saturated, input ready);
   modport sink   (input valid, input rotated_x, input rotated_y,
                   input saturated, output ready);
endinterface

>>> hw/rtl/rpac_cordic_stage.sv
// ============================================================================
// rpac_cordic_stage
// One registered CORDIC micro-rotation: shift-add on x/y, table step on z.
// ============================================================================
module rpac_cordic_stage #(
   parameter int                     DATA_WIDTH = 44,
   parameter int                     SHIFT      = 0,
   parameter rpac_pkg::angle_acc_type ANGLE     = 32'sd0
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic signed [DATA_WIDTH-1:0]   src_x,
   input  logic signed [DATA_WIDTH-1:0]   src_y,
   input  rpac_pkg::angle_acc_type        src_z,
   output logic signed [DATA_WIDTH-1:0]   x_ff,
   output logic signed [DATA_WIDTH-1:0]   y_ff,
   output rpac_pkg::angle_acc_type        z_ff
);

   logic                         turn_ccw;
   logic signed [DATA_WIDTH-1:0] x_shr;
   logic signed [DATA_WIDTH-1:0] y_shr;
   logic signed [DATA_WIDTH-1:0] x_in;
   logic signed [DATA_WIDTH-1:0] y_in;
   rpac_pkg::angle_acc_type      z_in;

   // residual >= 0 rotates counterclockwise; shifts floor
   always_comb begin
      turn_ccw = !src_z[rpac_pkg::ZWIDTH-1];
      x_shr    = src_x >>> SHIFT;
      y_shr    = src_y >>> SHIFT;
      if (turn_ccw) begin
         x_in = src_x - y_shr;
         y_in = src_y + x_shr;
         z_in = src_z - ANGLE;
      end else begin
         x_in = src_x + y_shr;
         y_in = src_y - x_shr;
         z_in = src_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

>>> hw/rtl/rotate_point_about_center_unit.sv
// ============================================================================
// rotate_point_about_center_unit
// Rotates a Q16.16 point about a center by a 16-bit fraction of a full turn,
// using an exact quarter-turn swap and a pipelined, gain-compensated CORDIC.
// ============================================================================
//
//   channel  | port     | direction | beat contents
//   ---------+----------+-----------+-----------------------------------------
//   request  | req_bus  | sink      | point_x, point_y, center_x, center_y,
//            |          |           | turn_angle
//   response | rsp_bus  | source    | rotated_x, rotated_y, saturated
//
// One request beat per cycle while the skid reg is empty, one response beat per
// request, in order. Pipe regs: prep, one stage per micro-rotation, magnitude,
// gain multiply, product sum, round, center add/clamp, output reg.
// Synchronous active-high reset clears only the valid bits; no clearing pass.
// A response not taken parks in the output reg; the next one lands in a skid
// reg, and while the skid is full the whole pipe holds and req_bus.ready is low.
// req_bus.ready is a register output (no combinational path from rsp_bus.ready).
// ============================================================================
`include "rotate_point_about_center_unit_defines.svh"

module rotate_point_about_center_unit #(
   parameter int CORDIC_STAGES = 16,
   parameter int COORD_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   rpac_req_if.sink    req_bus,
   rpac_rsp_if.source  rsp_bus
);

   // ------------------------------------------------------------------------
   // Sizing
   // ------------------------------------------------------------------------
   localparam int NSTG = (CORDIC_STAGES < rpac_pkg::MIN_STAGES) ? rpac_pkg::MIN_STAGES :
                         (CORDIC_STAGES > rpac_pkg::MAX_STAGES) ? rpac_pkg::MAX_STAGES :
                         CORDIC_STAGES;
   localparam int GI   = (NSTG - rpac_pkg::MIN_STAGES > rpac_pkg::GAIN_ENTRIES - 1) ?
                         rpac_pkg::GAIN_ENTRIES - 1 : NSTG - rpac_pkg::MIN_STAGES;
   localparam rpac_pkg::gain_type GAIN = rpac_pkg::GAIN_Q30[GI];

   localparam int OW  = COORD_WIDTH + 1;                    // exact offset
   localparam int DW  = COORD_WIDTH + rpac_pkg::GUARD_BITS + 4; // CORDIC datapath
   localparam int MW  = (DW > rpac_pkg::GAIN_SHIFT + 1) ? DW : rpac_pkg::GAIN_SHIFT + 1;
   localparam int LPW = 2 * rpac_pkg::GAIN_SHIFT;            // low partial product
   localparam int PW  = MW + 1;                             // scaled magnitude
   localparam int RW  = PW + 1;                             // signed, pre-round
   localparam int QW  = RW - rpac_pkg::GUARD_BITS;          // rounded
   localparam int SW  = QW + 1;                             // center + rounded
   localparam int ZW  = rpac_pkg::ZWIDTH;
   localparam int AW  = rpac_pkg::ANGLE_WIDTH;

   // pipe stage numbers
   localparam int ST_MAG  = NSTG + 1;
   localparam int NP      = NSTG + 6;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [RW-1:0] ROUND_HALF = RW'(1) << (rpac_pkg::GUARD_BITS - 1);

   // ------------------------------------------------------------------------
   // Pipe control: one global advance, gated only by a full skid reg
   // ------------------------------------------------------------------------
   logic          advance;
   logic          skid_vld_ff;
   logic [NP-1:0] vld_ff;
   logic [NP-1:0] vld_in;

   assign advance       = !skid_vld_ff;
   assign req_bus.ready = advance;
   assign vld_in        = {vld_ff[NP-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // center rides along to the final add
   logic signed [COORD_WIDTH-1:0] cx_ff [NP-1];
   logic signed [COORD_WIDTH-1:0] cy_ff [NP-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff[0] <= req_bus.center_x;
         cy_ff[0] <= req_bus.center_y;
         for (int k = 1; k < NP - 1; k++) begin
            cx_ff[k] <= cx_ff[k-1];
            cy_ff[k] <= cy_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 0: quadrant fold and offset. Quadrant = angle rounded to the
   // nearest quarter turn; residual lands in [-1/8, +1/8) turn. The swap and
   // negate are folded into the operand order of a single subtract.
   // ------------------------------------------------------------------------
   rpac_pkg::quad_type    quad;
   logic [AW-1:0]         resid;
   logic signed [OW-1:0]  px, py, cx, cy;
   logic signed [OW-1:0]  xa, xb, ya, yb;
   logic signed [OW-1:0]  x0_in, y0_in;
   logic signed [OW-1:0]  x0_ff, y0_ff;
   rpac_pkg::angle_acc_type z0_in, z0_ff;

   always_comb begin
      quad  = rpac_pkg::quad_type'(req_bus.turn_angle[AW-1:AW-2] +
                                   2'(req_bus.turn_angle[AW-3]));
      resid = req_bus.turn_angle - {2'(quad), {(AW-2){1'b0}}};
      z0_in = {resid, {(ZW-AW){1'b0}}};
      px = OW'(req_bus.point_x);
      py = OW'(req_bus.point_y);
      cx = OW'(req_bus.center_x);
      cy = OW'(req_bus.center_y);
      case (quad)
         rpac_pkg::QUAD_0: begin
            xa = px; xb = cx; ya = py; yb = cy;
         end
         rpac_pkg::QUAD_90: begin
            xa = cy; xb = py; ya = px; yb = cx;
         end
         rpac_pkg::QUAD_180: begin
            xa = cx; xb = px; ya = cy; yb = py;
         end
         rpac_pkg::QUAD_270: begin
            xa = py; xb = cy; ya = cx; yb = px;
         end
         default: begin
            xa = px; xb = cx; ya = py; yb = cy;
         end
      endcase
      x0_in = xa - xb;
      y0_in = ya - yb;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         z0_ff <= z0_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 1..NSTG: micro-rotations on guard-scaled offset
   // ------------------------------------------------------------------------
   logic signed [DW-1:0]    cordic_x [NSTG+1];
   logic signed [DW-1:0]    cordic_y [NSTG+1];
   rpac_pkg::angle_acc_type cordic_z [NSTG+1];

   assign cordic_x[0] = DW'(x0_ff) <<< rpac_pkg::GUARD_BITS;
   assign cordic_y[0] = DW'(y0_ff) <<< rpac_pkg::GUARD_BITS;
   assign cordic_z[0] = z0_ff;

   for (genvar i = 0; i < NSTG; i++) begin : g_rot
      rpac_cordic_stage #(
         .DATA_WIDTH (DW),
         .SHIFT      (i),
         .ANGLE      (rpac_pkg::ATAN_TURN32[i])
      ) u_stage (
         .clock (clock),
         .load  (advance),
         .src_x (cordic_x[i]),
         .src_y (cordic_y[i]),
         .src_z (cordic_z[i]),
         .x_ff  (cordic_x[i+1]),
         .y_ff  (cordic_y[i+1]),
         .z_ff  (cordic_z[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // Gain compensation on magnitudes: floor(|v| * K / 2^30), sign restored
   // at rounding. Split at bit 30 so both products stay within 30x30.
   // ------------------------------------------------------------------------
   logic signed [DW-1:0] xl_neg, yl_neg;
   logic [MW-1:0]        mx_in, my_in, mx_ff, my_ff;
   logic                 sx_ff [ST_MAG:NP-3];
   logic                 sy_ff [ST_MAG:NP-3];

   always_comb begin
      xl_neg = -cordic_x[NSTG];
      yl_neg = -cordic_y[NSTG];
      mx_in  = MW'($unsigned(cordic_x[NSTG][DW-1] ? xl_neg : cordic_x[NSTG]));
      my_in  = MW'($unsigned(cordic_y[NSTG][DW-1] ? yl_neg : cordic_y[NSTG]));
   end

   logic [LPW-1:0] x_lo_in, y_lo_in, x_lo_ff, y_lo_ff;
   logic [MW-1:0]  x_hi_in, y_hi_in, x_hi_ff, y_hi_ff;
   logic [PW-1:0]  pmx_in, pmy_in, pmx_ff, pmy_ff;

   always_comb begin
      x_lo_in = LPW'(mx_ff[rpac_pkg::GAIN_SHIFT-1:0]) * LPW'(GAIN);
      y_lo_in = LPW'(my_ff[rpac_pkg::GAIN_SHIFT-1:0]) * LPW'(GAIN);
      x_hi_in = MW'(mx_ff[MW-1:rpac_pkg::GAIN_SHIFT]) * MW'(GAIN);
      y_hi_in = MW'(my_ff[MW-1:rpac_pkg::GAIN_SHIFT]) * MW'(GAIN);
      pmx_in  = PW'(x_hi_ff) + PW'(x_lo_ff[LPW-1:rpac_pkg::GAIN_SHIFT]);
      pmy_in  = PW'(y_hi_ff) + PW'(y_lo_ff[LPW-1:rpac_pkg::GAIN_SHIFT]);
   end

   // round half up while dropping guard bits; negative side is HALF - p
   logic signed [RW-1:0] tx, ty;
   logic signed [QW-1:0] qx_in, qy_in, qx_ff, qy_ff;

   always_comb begin
      tx    = sx_ff[NSTG+3] ? (ROUND_HALF - RW'(pmx_ff)) : (RW'(pmx_ff) + ROUND_HALF);
      ty    = sy_ff[NSTG+3] ? (ROUND_HALF - RW'(pmy_ff)) : (RW'(pmy_ff) + ROUND_HALF);
      qx_in = tx[RW-1:rpac_pkg::GUARD_BITS];
      qy_in = ty[RW-1:rpac_pkg::GUARD_BITS];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff          <= mx_in;
         my_ff          <= my_in;
         sx_ff[ST_MAG]  <= cordic_x[NSTG][DW-1];
         sy_ff[ST_MAG]  <= cordic_y[NSTG][DW-1];
         for (int k = ST_MAG + 1; k <= NP - 3; k++) begin
            sx_ff[k] <= sx_ff[k-1];
            sy_ff[k] <= sy_ff[k-1];
         end
         x_lo_ff <= x_lo_in;
         y_lo_ff <= y_lo_in;
         x_hi_ff <= x_hi_in;
         y_hi_ff <= y_hi_in;
         pmx_ff  <= pmx_in;
         pmy_ff  <= pmy_in;
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
      end
   end

   // ------------------------------------------------------------------------
   // Last pipe stage: add center back, clamp to the coordinate range
   // ------------------------------------------------------------------------
   function automatic logic [COORD_WIDTH:0] clamp_coord(input logic signed [SW-1:0] sum);
      logic                 pos_ovf;
      logic                 neg_ovf;
      logic [COORD_WIDTH:0] res;
      pos_ovf = !sum[SW-1] && (|sum[SW-2:COORD_WIDTH-1]);
      neg_ovf = sum[SW-1] && !(&sum[SW-2:COORD_WIDTH-1]);
      if (pos_ovf) begin
         res = {1'b1, COORD_MAX};
      end else if (neg_ovf) begin
         res = {1'b1, COORD_MIN};
      end else begin
         res = {1'b0, sum[COORD_WIDTH-1:0]};
      end
      return res;
   endfunction

   logic signed [SW-1:0]          sum_x, sum_y;
   logic [COORD_WIDTH:0]          clx, cly;
   logic signed [COORD_WIDTH-1:0] rx_in, ry_in, rx_ff, ry_ff;
   logic                          sat_in, sat_ff;

   always_comb begin
      sum_x  = SW'(cx_ff[NP-2]) + SW'(qx_ff);
      sum_y  = SW'(cy_ff[NP-2]) + SW'(qy_ff);
      clx    = clamp_coord(sum_x);
      cly    = clamp_coord(sum_y);
      rx_in  = clx[COORD_WIDTH-1:0];
      ry_in  = cly[COORD_WIDTH-1:0];
      sat_in = clx[COORD_WIDTH] | cly[COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         sat_ff <= sat_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output reg plus one-beat skid
   // ------------------------------------------------------------------------
   logic out_vld_ff, out_vld_in;
   logic skid_vld_in;
   logic take, pipe_done, load_out, load_skid, out_from_skid;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic                          out_sat_ff, skid_sat_ff;

   always_comb begin
      take          = out_vld_ff && rsp_bus.ready;
      pipe_done     = advance && vld_ff[NP-1];
      out_vld_in    = out_vld_ff;
      skid_vld_in   = skid_vld_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_from_skid = 1'b0;
      if (skid_vld_ff) begin
         if (take) begin
            load_out      = 1'b1;
            out_from_skid = 1'b1;
            skid_vld_in   = 1'b0;
         end
      end else if (pipe_done) begin
         if (!out_vld_ff || take) begin
            load_out   = 1'b1;
            out_vld_in = 1'b1;
         end else begin
            load_skid   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_x_ff   <= out_from_skid ? skid_x_ff   : rx_ff;
         out_y_ff   <= out_from_skid ? skid_y_ff   : ry_ff;
         out_sat_ff <= out_from_skid ? skid_sat_ff : sat_ff;
      end
      if (load_skid) begin
         skid_x_ff   <= rx_ff;
         skid_y_ff   <= ry_ff;
         skid_sat_ff <= sat_ff;
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.rotated_x = out_x_ff;
   assign rsp_bus.rotated_y = out_y_ff;
   assign rsp_bus.saturated = out_sat_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `RPAC_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_bus.valid && req_bus.ready, vld_ff[0], "accepted beat did not enter stage 0")
   `RPAC_ASSERT_HOLDS(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff, "skid holds a beat while output is empty")
   `RPAC_ASSERT_NEXT(a_skid_kept, clock, reset, skid_vld_ff && !rsp_bus.ready, skid_vld_ff && $stable(skid_x_ff) && $stable(skid_y_ff), "parked skid beat lost or changed")
   `RPAC_ASSERT_HOLDS(a_sat_at_limit, clock, reset, rsp_bus.valid && rsp_bus.saturated, rsp_bus.rotated_x == COORD_MAX || rsp_bus.rotated_x == COORD_MIN || rsp_bus.rotated_y == COORD_MAX || rsp_bus.rotated_y == COORD_MIN, "saturated flag without a clamped coordinate")

endmodule

>>> verif/tb_top.sv
// ============================================================================
// tb_top - point rotation unit testbench
// Streams point/center/angle beats into the rotation unit and checks every
// response beat, in order, against a bit-exact fixed-point CORDIC predictor.
// Covers quarter turns, octant edges, origin and offset centers, saturation,
// random valid/ready idling, a long response hold-off and drain pauses.
// ============================================================================
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      COORD_W     = 32;
   localparam int      ANGLE_W     = rpac_pkg::ANGLE_WIDTH;
   localparam int      N_STAGES    = 16;
   // Latency through the unit's pipe registers, used to size the final drain wait
   localparam int      LATENCY     = N_STAGES + 7;
   localparam int      CLK_PERIOD  = 10;
   localparam int      N_RANDOM    = 830;
   localparam int      HOLD_CYCLES = 300;
   localparam int      HOLD_AFTER  = 150;
   localparam longint  MAX_CYCLES  = 300000;
   localparam int      MAX_PRINTS  = 40;

   typedef logic signed [COORD_W-1:0] coord_type;

   // One request beat plus the sender's pacing hints for it
   typedef struct {
      coord_type              px;
      coord_type              py;
      coord_type              cx;
      coord_type              cy;
      logic [ANGLE_W-1:0]     angle;
      bit                     wait_drain;  // hold off until nothing is in flight
      bit                     allow_idle;  // random gaps allowed around this beat
   } rotate_job_type;

   typedef struct {
      coord_type rx;
      coord_type ry;
      logic      sat;
   } rotated_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpac_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   rpac_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_bus ();

   rotate_point_about_center_unit #(
      .CORDIC_STAGES(N_STAGES),
      .COORD_WIDTH  (COORD_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   rotate_job_type    rotate_jobs[$];      // beats waiting to be offered
   rotated_point_type expected_points[$];  // predictions for accepted beats

   int     fail_count = 0;
   int     rsp_seen   = 0;
   longint cycle_count = 0;
   bit     quiet_stretch = 1'b0;        // no random idling on either side while set

   // driver state
   int             send_gap = 0;
   bit             next_valid;
   rotate_job_type cur_job;

   // receiver state
   int hold_left = 0;
   int recv_gap  = 0;
   bit long_hold_done = 1'b0;
   bit next_ready;

   // monitor scratch
   rotate_job_type    seen_job;
   rotated_point_type want;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Multiply by the Q30 gain, truncating the magnitude toward zero.
   function automatic longint scale_by_gain(longint v, longint unsigned k);
      longint unsigned mag, hi, lo, prod;
      if (v < 0)
         mag = longint'(-v);
      else
         mag = v;
      hi   = mag >> rpac_pkg::GAIN_SHIFT;
      lo   = mag & ((64'd1 << rpac_pkg::GAIN_SHIFT) - 1);
      prod = hi * k + ((lo * k) >> rpac_pkg::GAIN_SHIFT);
      if (v < 0)
         return -longint'(prod);
      return longint'(prod);
   endfunction

   function automatic longint clamp_coord(longint v, ref bit hit);
      longint top, bottom;
      top    = (64'sd1 <<< (COORD_W - 1)) - 1;
      bottom = -top - 1;
      if (v > top) begin
         hit = 1'b1;
         return top;
      end
      if (v < bottom) begin
         hit = 1'b1;
         return bottom;
      end
      return v;
   endfunction

   function automatic rotated_point_type predict_rotation(rotate_job_type job);
      rotated_point_type  res;
      longint             cx, cy, dx, dy, x, y, z, xs, ys, half;
      int unsigned        ang;
      rpac_pkg::quad_type quad;
      int                 n_st, gidx;
      bit                 hit;
      cx   = longint'(job.cx);
      cy   = longint'(job.cy);
      dx   = longint'(job.px) - cx;
      dy   = longint'(job.py) - cy;
      ang  = job.angle;
      hit  = 1'b0;
      // nearest quarter turn; the remainder lands in [-1/8, +1/8) turn
      quad = rpac_pkg::quad_type'(2'((ang + 32'h2000) >> 14));
      z    = (longint'(ang) - longint'(quad) * 64'sd16384) * 64'sd65536;
      if (z >= (64'sd1 <<< 31))
         z -= 64'sd1 <<< 32;

      // exact swap/negate for the quarter turns
      case (quad)
         rpac_pkg::QUAD_0: begin
            x = dx;  y = dy;
         end
         rpac_pkg::QUAD_90: begin
            x = -dy; y = dx;
         end
         rpac_pkg::QUAD_180: begin
            x = -dx; y = -dy;
         end
         default: begin
            x = dy;  y = -dx;
         end
      endcase
      x = x * (64'sd1 <<< rpac_pkg::GUARD_BITS);
      y = y * (64'sd1 <<< rpac_pkg::GUARD_BITS);

      n_st = N_STAGES;
      if (n_st < rpac_pkg::MIN_STAGES) n_st = rpac_pkg::MIN_STAGES;
      if (n_st > rpac_pkg::MAX_STAGES) n_st = rpac_pkg::MAX_STAGES;
      for (int i = 0; i < n_st; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(rpac_pkg::ATAN_TURN32[i]);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(rpac_pkg::ATAN_TURN32[i]);
         end
      end

      gidx = n_st - rpac_pkg::MIN_STAGES;
      if (gidx > rpac_pkg::GAIN_ENTRIES - 1) gidx = rpac_pkg::GAIN_ENTRIES - 1;
      x = scale_by_gain(x, longint'(rpac_pkg::GAIN_Q30[gidx]));
      y = scale_by_gain(y, longint'(rpac_pkg::GAIN_Q30[gidx]));

      // round half up while dropping guard bits, then add the center back
      half   = 64'sd1 <<< (rpac_pkg::GUARD_BITS - 1);
      res.rx = coord_type'(clamp_coord(cx + ((x + half) >>> rpac_pkg::GUARD_BITS), hit));
      res.ry = coord_type'(clamp_coord(cy + ((y + half) >>> rpac_pkg::GUARD_BITS), hit));
      res.sat = hit;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic add_job(coord_type px, coord_type py, coord_type cx, coord_type cy,
                          logic [ANGLE_W-1:0] angle, bit wait_drain = 1'b0,
                          bit allow_idle = 1'b1);
      rotate_job_type job;
      job.px = px;
      job.py = py;
      job.cx = cx;
      job.cy = cy;
      job.angle = angle;
      job.wait_drain = wait_drain;
      job.allow_idle = allow_idle;
      rotate_jobs.push_back(job);
   endtask

   // Full 32-bit pattern, shrunk by a random arithmetic shift so that both
   // huge (saturating) and modest magnitudes show up.
   function automatic coord_type random_coord();
      coord_type raw;
      raw = coord_type'($urandom);
      if ($urandom_range(0, 3) == 0)
         return raw;
      return raw >>> $urandom_range(1, 16);
   endfunction

   function automatic logic [ANGLE_W-1:0] random_angle();
      int base;
      if ($urandom_range(0, 9) < 7)
         return ANGLE_W'($urandom_range(0, 65535));
      // park near a quarter turn (residual sign flips) or an octant edge (quadrant flips)
      base = $urandom_range(0, 3) * 16384 + $urandom_range(0, 1) * 8192;
      return ANGLE_W'(base + $urandom_range(0, 4) - 2);
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offers queued beats, idles in random bursts, pauses for drains
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         // line is free: either nothing offered or the last beat was taken
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (rotate_jobs.size() > 0 &&
                      !(rotate_jobs[0].wait_drain &&
                        (expected_points.size() != 0 || req_bus.valid))) begin
            if (rotate_jobs[0].allow_idle && $urandom_range(0, 12) == 0) begin
               send_gap = $urandom_range(1, 16) - 1;
            end else begin
               cur_job = rotate_jobs.pop_front();
               req_bus.point_x    <= cur_job.px;
               req_bus.point_y    <= cur_job.py;
               req_bus.center_x   <= cur_job.cx;
               req_bus.center_y   <= cur_job.cy;
               req_bus.turn_angle <= cur_job.angle;
               quiet_stretch      <= !cur_job.allow_idle;
               next_valid = 1'b1;
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random ready bursts, plus one long hold-off that backs the
   // pipe up until the unit drops req ready
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         recv_gap  = 0;
      end else begin
         next_ready = 1'b1;
         if (!long_hold_done && rsp_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
         end else if (!quiet_stretch && $urandom_range(0, 10) == 0) begin
            recv_gap = $urandom_range(1, 16) - 1;
            next_ready = 1'b0;
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predicts on each accepted request beat, checks each accepted
   // response beat against the oldest prediction. Both happen here so the
   // push and pop of the queue never race.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_job.px    = req_bus.point_x;
            seen_job.py    = req_bus.point_y;
            seen_job.cx    = req_bus.center_x;
            seen_job.cy    = req_bus.center_y;
            seen_job.angle = req_bus.turn_angle;
            expected_points.push_back(predict_rotation(seen_job));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen++;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("response beat with none pending: x=%0d y=%0d",
                                         rsp_bus.rotated_x, rsp_bus.rotated_y));
            end else begin
               want = expected_points.pop_front();
               if (rsp_bus.rotated_x !== want.rx)
                  report_mismatch($sformatf("beat %0d rotated_x got %0d want %0d",
                                            rsp_seen, rsp_bus.rotated_x, want.rx));
               if (rsp_bus.rotated_y !== want.ry)
                  report_mismatch($sformatf("beat %0d rotated_y got %0d want %0d",
                                            rsp_seen, rsp_bus.rotated_y, want.ry));
               if (rsp_bus.saturated !== want.sat)
                  report_mismatch($sformatf("beat %0d saturated got %b want %b",
                                            rsp_seen, rsp_bus.saturated, want.sat));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d beats still pending",
                  cycle_count, expected_points.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence: reset, directed beats, random beats, drain, verdict
   // -------------------------------------------------------------------------
   initial begin
      // Directed: quarter turns, octant edges, tiny and full angles, origin
      // and offset centers, zero offset, and the saturating corners.
      add_job(32'sh0000_0000, 32'sh0000_0000, 32'sh0, 32'sh0, 16'h0000);
      add_job(32'sh0001_0000, 32'sh0000_0000, 32'sh0, 32'sh0, 16'h4000);
      add_job(32'sh0001_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 16'h8000);
      add_job(32'sh0001_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 16'hC000);
      add_job(32'sh0003_8000, -32'sh0001_4000, 32'sh0, 32'sh0, 16'hFFFF);
      add_job(32'sh0003_8000, -32'sh0001_4000, 32'sh0, 32'sh0, 16'h0001);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'h1FFF);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'h2000);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'h5FFF);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'h6000);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'h9FFF);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'hA000);
      add_job(32'sh0010_0000, 32'sh0005_0000, 32'sh0, 32'sh0, 16'hE000);
      add_job(32'sh0065_0000, -32'sh0032_0000, 32'sh0064_0000, -32'sh0032_0000,
              16'h4000);
      // point equal to center: zero offset
      add_job(32'sh1234_5678, -32'sh0765_4321, 32'sh1234_5678, -32'sh0765_4321,
              16'h1234);
      add_job(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              16'hFFFF);
      // widest offsets, overflow on the way back
      add_job(32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, 32'sh0, 16'h0000);
      add_job(32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF, 32'sh0, 16'h8000);
      add_job(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 16'h2000);
      add_job(32'sh8000_0000, 32'sh8000_0000, 32'sh0, 32'sh0, 16'h8000);
      add_job(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0, 16'h4000);
      add_job(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              16'hC000);

      // Random: each center coordinate is zero about a third of the time. Drain
      // pauses at a few points, a quiet stretch in the middle, and a quiet tail.
      for (int n = 0; n < N_RANDOM; n++) begin
         add_job(random_coord(), random_coord(),
                 ($urandom_range(0, 2) == 0) ? coord_type'(0) : random_coord(),
                 ($urandom_range(0, 2) == 0) ? coord_type'(0) : random_coord(),
                 random_angle(),
                 (n == 0 || n == 300 || n == 600),
                 !((n >= 400 && n < 480) || n >= N_RANDOM - 120));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for all beats to go out, then for every response
      while (rotate_jobs.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (expected_points.size() != 0)
         @(posedge clock);
      // catch any stray beat still inside the pipe
      repeat (2 * LATENCY) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> rotate_point_about_center_unit.f
+incdir+hw/rtl
hw/rtl/rpac_pkg.sv
hw/rtl/rpac_channel_if.sv
hw/rtl/rpac_cordic_stage.sv
hw/rtl/rotate_point_about_center_unit.sv
verif/tb_top.sv
